FILE: sv/u8vp_pkg.sv
package u8vp_pkg;

  // Bounds of the UTF-8 byte classes.
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] CONT_LO     = 8'h80;
  localparam logic [7:0] CONT_HI     = 8'hBF;
  localparam logic [7:0] LEAD2_LO    = 8'hC2;
  localparam logic [7:0] LEAD2_HI    = 8'hDF;
  localparam logic [7:0] LEAD3_LO    = 8'hE0;
  localparam logic [7:0] LEAD3_HI    = 8'hEF;
  localparam logic [7:0] LEAD4_LO    = 8'hF0;
  localparam logic [7:0] LEAD4_HI    = 8'hF4;

  // Lead bytes that narrow the range of the second byte.
  localparam logic [7:0] LEAD_E0     = 8'hE0;
  localparam logic [7:0] LEAD_ED     = 8'hED;
  localparam logic [7:0] LEAD_F0     = 8'hF0;
  localparam logic [7:0] LEAD_F4     = 8'hF4;
  localparam logic [7:0] SECOND_E0_LO = 8'hA0;
  localparam logic [7:0] SECOND_ED_HI = 8'h9F;
  localparam logic [7:0] SECOND_F0_LO = 8'h90;
  localparam logic [7:0] SECOND_F4_HI = 8'h8F;

  // U+FFFD encoded as UTF-8.
  localparam logic [7:0] REP_B0 = 8'hEF;
  localparam logic [7:0] REP_B1 = 8'hBF;
  localparam logic [7:0] REP_B2 = 8'hBD;

  // Position inside one replacement character.
  localparam logic [1:0] REP_POS0 = 2'd0;
  localparam logic [1:0] REP_POS1 = 2'd1;
  localparam logic [1:0] REP_POS2 = 2'd2;

  // Codes returned by lead_len besides the sequence lengths 2 to 4.
  localparam logic [2:0] LEN_BAD   = 3'd0;
  localparam logic [2:0] LEN_ASCII = 3'd1;

  // Decoder state that persists between input beats.
  typedef struct packed {
    logic [1:0] pc;   // held bytes of the open sequence
    logic [2:0] el;   // length of the open sequence, 0 when none
    logic       err;  // a replacement happened in this text
  } u8vp_state_t;

  // What one input beat produces: replacement characters first, then data bytes.
  typedef struct packed {
    logic [2:0]      n_fffd;
    logic [2:0]      n_data;
    logic [3:0][7:0] data;
    logic            eot;
    logic            valid;
  } u8vp_job_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    begin
      if (b < ASCII_LIMIT) begin
        len = LEN_ASCII;
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
        len = 3'd2;
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
        len = 3'd3;
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
        len = 3'd4;
      end else begin
        len = LEN_BAD;
      end
      return len;
    end
  endfunction

endpackage

FILE: sv/u8vp_decode.sv
module u8vp_decode
  import u8vp_pkg::*;
(
  input  logic [7:0]      in_byte,
  input  logic            eot,
  input  u8vp_state_t     st,
  input  logic [2:0][7:0] pend,
  output u8vp_job_t       job,
  output u8vp_state_t     st_nxt,
  output logic            pend_we,
  output logic [1:0]      pend_idx
);

  logic [7:0] lo;
  logic [7:0] hi;
  logic       acc;
  logic       do_begin;
  logic [2:0] len;
  logic [2:0] nf;
  logic       err_new;

  always_comb begin
    lo = CONT_LO;
    hi = CONT_HI;
    if (st.pc == 2'd1) begin
      case (pend[0])
        LEAD_E0: lo = SECOND_E0_LO;
        LEAD_ED: hi = SECOND_ED_HI;
        LEAD_F0: lo = SECOND_F0_LO;
        LEAD_F4: hi = SECOND_F4_HI;
        default: ;
      endcase
    end
    acc = (in_byte >= lo) && (in_byte <= hi);
  end

  always_comb begin
    job          = '0;
    st_nxt       = st;
    pend_we      = 1'b0;
    pend_idx     = st.pc;
    nf           = 3'd0;
    do_begin     = 1'b0;
    len          = lead_len(in_byte);

    // A completed sequence is the held bytes followed by this byte.
    job.data[0] = (st.pc > 2'd0) ? pend[0] : in_byte;
    job.data[1] = (st.pc > 2'd1) ? pend[1] : in_byte;
    job.data[2] = (st.pc > 2'd2) ? pend[2] : in_byte;
    job.data[3] = in_byte;

    if (st.pc == 2'd0) begin
      do_begin = 1'b1;
    end else if (acc) begin
      if (({1'b0, st.pc} + 3'd1) >= st.el) begin
        job.n_data = {1'b0, st.pc} + 3'd1;
        st_nxt.pc  = 2'd0;
        st_nxt.el  = 3'd0;
      end else begin
        pend_we   = 1'b1;
        st_nxt.pc = st.pc + 2'd1;
      end
    end else begin
      // Broken sequence: every held byte becomes one U+FFFD, then restart.
      nf        = {1'b0, st.pc};
      st_nxt.pc = 2'd0;
      st_nxt.el = 3'd0;
      do_begin  = 1'b1;
    end

    if (do_begin) begin
      case (len)
        LEN_BAD: begin
          nf = nf + 3'd1;
        end
        LEN_ASCII: begin
          job.n_data  = 3'd1;
          job.data[0] = in_byte;
        end
        default: begin
          pend_we   = 1'b1;
          pend_idx  = 2'd0;
          st_nxt.pc = 2'd1;
          st_nxt.el = len;
        end
      endcase
    end

    if (eot) begin
      nf = nf + {1'b0, st_nxt.pc};
    end

    err_new    = st.err | (nf != 3'd0);
    job.n_fffd = nf;
    job.eot    = eot;
    job.valid  = ~err_new;
    st_nxt.err = err_new;

    if (eot) begin
      st_nxt = '0;
    end
  end

endmodule

FILE: sv/utf8_validate_and_patch.sv
// Strict UTF-8 validator that patches bad input with U+FFFD. Each input beat
// carries one text byte, with in_tlast marking the final byte of a text. A
// multi-byte sequence is held until it completes and is then sent unchanged;
// an overlong form, a surrogate, a code point above U+10FFFF, a stray
// continuation byte or one of C0, C1, F5-FF turns each held byte (or the bad
// start byte) into EF BF BD, and the failing byte is tried again as a start.
// At the end of a text any held bytes are flushed as replacements, the last
// output beat of the text carries text_end, and text_was_valid tells whether
// the whole text passed untouched. An input byte is decoded in the cycle it is
// accepted and its results are loaded into an output job register, which
// sends one byte per cycle while out_tready is high. An input beat yields no
// output byte when it is only held, one for plain ASCII, two to four when a
// sequence completes, and up to twelve when three held bytes are flushed and
// the failing byte is itself replaced, either as a bad start or as a lead
// byte left open at the end of a text. The next input beat is taken in the
// same cycle as the last output beat of the previous one is accepted, so
// clean ASCII text streams at one byte per cycle while out_tready stays high.
module utf8_validate_and_patch
  import u8vp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // last_of_run
  output logic [2:0] out_tuser   // [0] is_replacement, [1] text_end, [2] text_was_valid
);

  // Decoder state and the bytes of the open sequence.
  u8vp_state_t     st_r;
  u8vp_state_t     st_nxt;
  logic [2:0][7:0] pend_r;
  logic            pend_we;
  logic [1:0]      pend_idx;
  u8vp_job_t       job;

  // Output job: replacement characters left, position in the current one,
  // data bytes left and the index of the next data byte.
  logic [2:0]      f_left_r,  f_left_nxt;
  logic [1:0]      sub_r,     sub_nxt;
  logic [2:0]      d_left_r,  d_left_nxt;
  logic [1:0]      d_idx_r,   d_idx_nxt;
  logic [3:0][7:0] data_r;
  logic            eot_r;
  logic            valid_r;

  logic in_acc;
  logic out_acc;
  logic busy;
  logic last_beat;

  u8vp_decode u_decode (
    .in_byte  (in_tdata),
    .eot      (in_tlast),
    .st       (st_r),
    .pend     (pend_r),
    .job      (job),
    .st_nxt   (st_nxt),
    .pend_we  (pend_we),
    .pend_idx (pend_idx)
  );

  assign busy      = (f_left_r != 3'd0) || (d_left_r != 3'd0);
  assign last_beat = ((f_left_r == 3'd1) && (sub_r == REP_POS2) && (d_left_r == 3'd0))
                  || ((f_left_r == 3'd0) && (d_left_r == 3'd1));
  assign out_acc   = out_tvalid && out_tready;
  // A new beat can enter while the last result of the previous one leaves.
  assign in_tready = !busy || (out_acc && last_beat);
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = busy;
  assign out_tlast  = last_beat;

  always_comb begin
    out_tuser[0] = (f_left_r != 3'd0);
    out_tuser[1] = last_beat && eot_r;
    out_tuser[2] = last_beat && eot_r && valid_r;
    if (f_left_r != 3'd0) begin
      case (sub_r)
        REP_POS0: out_tdata = REP_B0;
        REP_POS1: out_tdata = REP_B1;
        default:  out_tdata = REP_B2;
      endcase
    end else begin
      out_tdata = data_r[d_idx_r];
    end
  end

  always_comb begin
    f_left_nxt = f_left_r;
    sub_nxt    = sub_r;
    d_left_nxt = d_left_r;
    d_idx_nxt  = d_idx_r;
    if (out_acc) begin
      if (f_left_r != 3'd0) begin
        if (sub_r == REP_POS2) begin
          sub_nxt    = REP_POS0;
          f_left_nxt = f_left_r - 3'd1;
        end else begin
          sub_nxt = sub_r + 2'd1;
        end
      end else begin
        d_left_nxt = d_left_r - 3'd1;
        d_idx_nxt  = d_idx_r + 2'd1;
      end
    end
    if (in_acc) begin
      f_left_nxt = job.n_fffd;
      sub_nxt    = REP_POS0;
      d_left_nxt = job.n_data;
      d_idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= '0;
      f_left_r <= 3'd0;
      sub_r    <= REP_POS0;
      d_left_r <= 3'd0;
      d_idx_r  <= 2'd0;
    end else begin
      f_left_r <= f_left_nxt;
      sub_r    <= sub_nxt;
      d_left_r <= d_left_nxt;
      d_idx_r  <= d_idx_nxt;
      if (in_acc) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      data_r  <= job.data;
      eot_r   <= job.eot;
      valid_r <= job.valid;
      if (pend_we) begin
        pend_r[pend_idx] <= in_tdata;
      end
    end
  end

  // An open sequence always has fewer held bytes than its length.
  a_open_seq: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r.pc == 2'd0) == (st_r.el == 3'd0)) && ({1'b0, st_r.pc} < st_r.el || st_r.el == 3'd0))
    else $error("open sequence bookkeeping is inconsistent");

  // The end of a text always produces at least one output beat.
  a_eot_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> out_tvalid)
    else $error("end of text produced no output");

  // The validity flag appears only on the final beat of a text.
  a_valid_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> (out_tuser[1] && out_tlast && !out_tuser[0]))
    else $error("text_was_valid outside the end of a clean text");

  // Decoder state does not move without an accepted input beat.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tvalid && in_tready) |=> $stable(st_r))
    else $error("decoder state changed without an input beat");

endmodule
